// ===== rtl/pfdf_pkg.sv =====
// Types, constants and fixed-point helpers shared by the degradation function unit.
// Used by pfdf_cfg and phase_field_degradation_function_unit; depends on nothing.
`default_nettype none

package pfdf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int PH_W      = 24;
    localparam int OUT_W     = 25;
    localparam int TDO_W     = ((3 * OUT_W + 7) / 8) * 8;
    localparam int UW        = FRAC_BITS + 1;
    localparam int OPW       = FRAC_BITS + 4;
    localparam int WW        = (OPW + 9 > OUT_W + 1) ? OPW + 9 : OUT_W + 1;
    localparam int CW        = ((PH_W > UW) ? PH_W : UW) + 1;
    localparam int NCH       = 15;
    localparam int NST       = NCH + 5;
    localparam int AW        = 4;
    localparam int DW        = 32;
    localparam int ONE_INT   = 1 << FRAC_BITS;
    localparam int HALF_INT  = 1 << (FRAC_BITS - 1);
    localparam int SH_UP     = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int SH_DN     = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
    localparam int RND_INT   = (SH_DN > 0) ? (1 << (SH_DN - 1)) : 0;
    localparam int OUT_MAX_I = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_MIN_I = -(1 << (OUT_W - 1));

    typedef logic [UW-1:0]           uv_t;
    typedef logic signed [OPW-1:0]   op_t;
    typedef logic signed [WW-1:0]    wide_t;
    typedef logic signed [OUT_W-1:0] res_t;

    localparam uv_t ONE  = uv_t'(ONE_INT);
    localparam uv_t TH20 = uv_t'((2 * ONE_INT + 5) / 10);
    localparam uv_t TH50 = uv_t'(ONE_INT / 2);
    localparam uv_t TH80 = uv_t'((8 * ONE_INT + 5) / 10);

    typedef enum logic [3:0] {
        MODE_NONE     = 4'd0,
        MODE_LIN      = 4'd1,
        MODE_LIN_NR   = 4'd2,
        MODE_QUAD     = 4'd3,
        MODE_QUAD_NR  = 4'd4,
        MODE_CUBIC    = 4'd5,
        MODE_CUBIC_NR = 4'd6,
        MODE_POWER    = 4'd7,
        MODE_CZM      = 4'd8,
        MODE_STEP20   = 4'd9,
        MODE_STEP50   = 4'd10,
        MODE_STEP80   = 4'd11
    } mode_t;

    typedef enum logic [1:0] {
        REG_MODE  = 2'd0,
        REG_K0    = 2'd1,
        REG_POWER = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [3:0] mode;
        uv_t        k0;
        uv_t        km;
        logic [3:0] power;
        logic [7:0] coef;
    } cfg_t;

    typedef struct packed {
        uv_t u;
        uv_t phc;
        uv_t pw;
        uv_t u2;
        uv_t u3;
        uv_t e0;
        uv_t e1;
        uv_t e2;
    } chain_t;

    typedef struct packed {
        op_t dop;
        op_t sop;
        op_t cop;
        uv_t u;
        uv_t u2;
        uv_t u3;
        uv_t phc;
    } opnd_t;

    typedef struct packed {
        wide_t d;
        wide_t s;
        wide_t c;
        logic  bad;
    } scl_t;

    typedef struct packed {
        res_t deg;
        res_t slp;
        res_t crv;
        logic bad;
    } out_t;

    // rounded product, halves away from zero
    function automatic op_t fmul(op_t a, op_t b);
        logic             neg;
        logic [OPW-1:0]   ma;
        logic [OPW-1:0]   mb;
        logic [2*OPW-1:0] pr;
        logic [2*OPW-1:0] rr;
        neg = a[OPW-1] ^ b[OPW-1];
        ma  = a[OPW-1] ? unsigned'(-a) : unsigned'(a);
        mb  = b[OPW-1] ? unsigned'(-b) : unsigned'(b);
        pr  = {{OPW{1'b0}}, ma} * {{OPW{1'b0}}, mb};
        rr  = (pr + (2*OPW)'(HALF_INT)) >> FRAC_BITS;
        return neg ? -signed'(rr[OPW-1:0]) : signed'(rr[OPW-1:0]);
    endfunction

    function automatic op_t op_of(uv_t x);
        return signed'({{(OPW-UW){1'b0}}, x});
    endfunction

    function automatic wide_t wd(op_t x);
        return signed'({{(WW-OPW){x[OPW-1]}}, x});
    endfunction

    function automatic uv_t pw_mul(uv_t a, uv_t b);
        op_t r;
        r = fmul(op_of(a), op_of(b));
        return r[UW-1:0];
    endfunction

    function automatic uv_t k0_of(logic [15:0] rs);
        logic [16:0] t;
        t = ({1'b0, rs} + 17'(RND_INT)) >> SH_DN;
        if (FRAC_BITS >= 16)
        begin
            return uv_t'(rs) << SH_UP;
        end
        return uv_t'(t);
    endfunction

    function automatic res_t sat(wide_t v);
        if (v > wide_t'(OUT_MAX_I))
        begin
            return res_t'(OUT_MAX_I);
        end
        if (v < wide_t'(OUT_MIN_I))
        begin
            return res_t'(OUT_MIN_I);
        end
        return v[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pfdf_cfg.sv =====
// Configuration register file on an APB-style port: mode, residual stiffness, power order.
// Depends on pfdf_pkg; presents the decoded settings as one cfg_t.
`default_nettype none

module pfdf_cfg
    import pfdf_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [AW-1:0] paddr,
    input  wire logic [DW-1:0] pwdata,
    output logic      [DW-1:0] prdata,
    output cfg_t               cfg
);

    logic [3:0]  mode_reg;
    logic [15:0] k0_reg;
    logic [3:0]  power_reg;
    logic [7:0]  coef_reg;
    logic [7:0]  coef_next;
    logic [1:0]  idx;
    logic        wr;
    uv_t         k0;

    assign idx = paddr[3:2];
    assign wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_QUAD;
            k0_reg    <= '0;
            power_reg <= 4'd2;
            coef_reg  <= 8'd2;
        end
        else
        begin
            coef_reg <= coef_next;
            if (wr && idx == REG_MODE)
            begin
                mode_reg <= pwdata[3:0];
            end
            if (wr && idx == REG_K0)
            begin
                k0_reg <= pwdata[15:0];
            end
            if (wr && idx == REG_POWER)
            begin
                power_reg <= pwdata[3:0];
            end
        end
    end

    // p*(p-1); zero for p of 0 or 1
    assign coef_next = 8'({4'd0, power_reg} * ({4'd0, power_reg} - 8'd1));

    always_comb
    begin
        unique case (idx)
            REG_MODE:  prdata = {{(DW-4){1'b0}}, mode_reg};
            REG_K0:    prdata = {{(DW-16){1'b0}}, k0_reg};
            REG_POWER: prdata = {{(DW-4){1'b0}}, power_reg};
            default:   prdata = '0;
        endcase
    end

    assign k0        = k0_of(k0_reg);
    assign cfg.mode  = mode_reg;
    assign cfg.k0    = k0;
    assign cfg.km    = ONE - k0;
    assign cfg.power = power_reg;
    assign cfg.coef  = coef_reg;

endmodule

`default_nettype wire

// ===== rtl/phase_field_degradation_function_unit.sv =====
// Top level: phase-field degradation function with first and second derivatives.
// Depends on pfdf_pkg and pfdf_cfg.
//
//  channel | dir | handshake         | payload
//  s_*     | in  | s_tvalid/s_tready | s_tdata: phase
//  m_*     | out | m_tvalid/m_tready | m_tdata: degradation, slope, curvature; m_tuser: bad_mode
//  p*      | in  | psel/penable      | damage_mode, residual_stiffness, power_order
//
// One request per cycle while the output is not stalled; the stages are the input clamp, the chain of fifteen
// rounded multiplies that builds the powers of (1 - phase), then operand select,
// km multiply, scaling and saturation.
// Each stage loads when it is empty or its successor loads, so bubbles close up under stall.
// rst_n clears the valid bits and sets the configuration registers to their defaults; data
// registers are not reset and there is no clearing pass.
`default_nettype none

module phase_field_degradation_function_unit
    import pfdf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [PH_W-1:0]  s_tdata,   // [23:0] phase
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [TDO_W-1:0] m_tdata,   // [24:0] degradation, [49:25] slope,
                                             // [74:50] curvature, rest zero
    output logic                  m_tuser,   // [0] bad_mode
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [AW-1:0]    paddr,
    input  wire logic [DW-1:0]    pwdata,
    output logic      [DW-1:0]    prdata,
    output logic                  pready
);

    localparam int S_OP  = NCH + 1;
    localparam int S_MUL = NCH + 2;
    localparam int S_SCL = NCH + 3;
    localparam int S_OUT = NCH + 4;

    cfg_t cfg;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] v_next;
    logic [NST:0]   rdy;

    chain_t chain_reg  [0:NCH];
    chain_t chain_next [0:NCH];
    opnd_t  op_reg;
    opnd_t  op_next;
    opnd_t  mul_reg;
    opnd_t  mul_next;
    scl_t   scl_reg;
    scl_t   scl_next;
    out_t   out_reg;
    out_t   out_next;

    assign pready = 1'b1;

    pfdf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // ---- flow control ----
    assign rdy[NST] = m_tready;

    genvar g;
    generate
        for (g = 0; g < NST; g++)
        begin : g_rdy
            assign rdy[g]    = !v_reg[g] || rdy[g+1];
            if (g == 0)
            begin : g_first
                assign v_next[g] = rdy[g] ? s_tvalid : v_reg[g];
            end
            else
            begin : g_rest
                assign v_next[g] = rdy[g] ? v_reg[g-1] : v_reg[g];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign s_tready = rdy[0];

    // ---- entry: clamp ----
    always_comb
    begin
        logic [CW-1:0] phu;
        uv_t           phc;
        phu = CW'(s_tdata[PH_W-2:0]);
        if (s_tdata[PH_W-1])
        begin
            phc = '0;
        end
        else if (phu > CW'(ONE))
        begin
            phc = ONE;
        end
        else
        begin
            phc = uv_t'(phu);
        end
        chain_next[0]     = '0;
        chain_next[0].phc = phc;
        chain_next[0].u   = ONE - phc;
        chain_next[0].pw  = ONE;
        if ({1'b0, cfg.power} == 5'd0)
        begin
            chain_next[0].e2 = ONE;
        end
        if ({1'b0, cfg.power} == 5'd1)
        begin
            chain_next[0].e1 = ONE;
        end
        if ({1'b0, cfg.power} == 5'd2)
        begin
            chain_next[0].e0 = ONE;
        end
    end

    // ---- power chain: one rounded multiply per stage ----
    generate
        for (g = 1; g <= NCH; g++)
        begin : g_chain
            always_comb
            begin
                uv_t pw;
                pw            = pw_mul(chain_reg[g-1].pw, chain_reg[g-1].u);
                chain_next[g] = chain_reg[g-1];
                chain_next[g].pw = pw;
                if (g == 2)
                begin
                    chain_next[g].u2 = pw;
                end
                if (g == 3)
                begin
                    chain_next[g].u3 = pw;
                end
                if ({1'b0, cfg.power} == 5'(g))
                begin
                    chain_next[g].e2 = pw;
                end
                if ({1'b0, cfg.power} == 5'(g + 1))
                begin
                    chain_next[g].e1 = pw;
                end
                if ({1'b0, cfg.power} == 5'(g + 2))
                begin
                    chain_next[g].e0 = pw;
                end
            end
        end

        for (g = 0; g <= NCH; g++)
        begin : g_chain_reg
            always_ff @(posedge clk)
            begin
                if (rdy[g])
                begin
                    chain_reg[g] <= chain_next[g];
                end
            end
        end
    endgenerate

    // ---- operand select ----
    always_comb
    begin
        op_t ou;
        op_t ou2;
        op_t ou3;
        ou  = op_of(chain_reg[NCH].u);
        ou2 = op_of(chain_reg[NCH].u2);
        ou3 = op_of(chain_reg[NCH].u3);
        op_next     = '0;
        op_next.u   = chain_reg[NCH].u;
        op_next.u2  = chain_reg[NCH].u2;
        op_next.u3  = chain_reg[NCH].u3;
        op_next.phc = chain_reg[NCH].phc;
        case (cfg.mode)
            MODE_LIN:
            begin
                op_next.dop = ou;
            end
            MODE_QUAD:
            begin
                op_next.dop = ou2;
                op_next.sop = ou;
            end
            MODE_CUBIC:
            begin
                op_next.dop = ou3;
                op_next.sop = ou2;
                op_next.cop = ou;
            end
            MODE_POWER:
            begin
                op_next.dop = op_of(chain_reg[NCH].e2);
                op_next.sop = op_of(chain_reg[NCH].e1);
                op_next.cop = op_of(chain_reg[NCH].e0);
            end
            MODE_CZM:
            begin
                op_next.dop = (ou2 <<< 1) - ou3;
                op_next.sop = (ou2 <<< 1) + ou2 - (ou <<< 2);
                op_next.cop = (op_of(ONE) <<< 2) - ((ou <<< 2) + (ou <<< 1));
            end
            default:
            begin
                op_next.dop = '0;
            end
        endcase
    end

    // ---- km multiply ----
    always_comb
    begin
        mul_next     = op_reg;
        mul_next.dop = fmul(op_reg.dop, op_of(cfg.km));
        mul_next.sop = fmul(op_reg.sop, op_of(cfg.km));
        mul_next.cop = fmul(op_reg.cop, op_of(cfg.km));
    end

    // ---- scaling per mode ----
    always_comb
    begin
        wide_t pd;
        wide_t ps;
        wide_t pc;
        wide_t wk0;
        wide_t wkm;
        wide_t wone;
        wide_t wu;
        wide_t wu2;
        pd   = wd(mul_reg.dop);
        ps   = wd(mul_reg.sop);
        pc   = wd(mul_reg.cop);
        wk0  = wd(op_of(cfg.k0));
        wkm  = wd(op_of(cfg.km));
        wone = wd(op_of(ONE));
        wu   = wd(op_of(mul_reg.u));
        wu2  = wd(op_of(mul_reg.u2));
        scl_next = '0;
        case (cfg.mode)
            MODE_NONE:
            begin
                scl_next.d = wone;
            end
            MODE_LIN:
            begin
                scl_next.d = pd + wk0;
                scl_next.s = -wkm;
            end
            MODE_LIN_NR:
            begin
                scl_next.d = wu;
                scl_next.s = -wone;
            end
            MODE_QUAD:
            begin
                scl_next.d = pd + wk0;
                scl_next.s = -(ps <<< 1);
                scl_next.c = wkm <<< 1;
            end
            MODE_QUAD_NR:
            begin
                scl_next.d = wu2;
                scl_next.s = -(wu <<< 1);
                scl_next.c = wone <<< 1;
            end
            MODE_CUBIC:
            begin
                scl_next.d = pd + wk0;
                scl_next.s = -((ps <<< 1) + ps);
                scl_next.c = (pc <<< 2) + (pc <<< 1);
            end
            MODE_CUBIC_NR:
            begin
                scl_next.d = wd(op_of(mul_reg.u3));
                scl_next.s = -((wu2 <<< 1) + wu2);
                scl_next.c = (wu <<< 2) + (wu <<< 1);
            end
            MODE_POWER:
            begin
                scl_next.d = pd + wk0;
                scl_next.s = -(ps * wide_t'(cfg.power));
                scl_next.c = pc * wide_t'(cfg.coef);
            end
            MODE_CZM:
            begin
                scl_next.d = pd + wk0;
                scl_next.s = ps;
                scl_next.c = pc;
            end
            MODE_STEP20:
            begin
                scl_next.d = (mul_reg.phc < TH20) ? wone : '0;
            end
            MODE_STEP50:
            begin
                scl_next.d = (mul_reg.phc < TH50) ? wone : '0;
            end
            MODE_STEP80:
            begin
                scl_next.d = (mul_reg.phc < TH80) ? wone : '0;
            end
            default:
            begin
                scl_next.bad = 1'b1;
            end
        endcase
    end

    // ---- saturation ----
    always_comb
    begin
        out_next.deg = sat(scl_reg.d);
        out_next.slp = sat(scl_reg.s);
        out_next.crv = sat(scl_reg.c);
        out_next.bad = scl_reg.bad;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[S_OP])
        begin
            op_reg <= op_next;
        end
        if (rdy[S_MUL])
        begin
            mul_reg <= mul_next;
        end
        if (rdy[S_SCL])
        begin
            scl_reg <= scl_next;
        end
        if (rdy[S_OUT])
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = v_reg[S_OUT];
    assign m_tdata  = {{(TDO_W-3*OUT_W){1'b0}}, out_reg.crv, out_reg.slp, out_reg.deg};
    assign m_tuser  = out_reg.bad;

    // ---- assertions ----
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("undefined mode request carries non-zero results");

    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input held off while output side is free");

    a_bad_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == (cfg.mode > MODE_STEP80)))
        else $error("bad_mode disagrees with mode register");

    a_step_flat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (cfg.mode == MODE_STEP20 || cfg.mode == MODE_STEP50
            || cfg.mode == MODE_STEP80)) |-> (out_reg.slp == '0 && out_reg.crv == '0))
        else $error("step mode with non-zero derivatives");

endmodule

`default_nettype wire

// ===== tb/sv/pfdf_result_checker.sv =====
// Watches the phase and result streams and the register port of the degradation unit,
// predicts each result from its own register copy and compares field by field.
// Depends on pfdf_pkg for widths, mode codes and register indexes.
module pfdf_result_checker
    import pfdf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [PH_W-1:0]  s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [TDO_W-1:0] m_tdata,
    input  logic             m_tuser,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic             pready,
    input  logic [AW-1:0]    paddr,
    input  logic [DW-1:0]    pwdata,
    output int               mismatches,
    output int               outstanding
);

    typedef struct packed {
        res_t deg;
        res_t slp;
        res_t crv;
        logic bad;
    } deg_result_t;

    deg_result_t expected_results[$];

    logic [3:0]  cur_mode;
    logic [15:0] cur_k0;
    logic [3:0]  cur_order;

    function automatic longint round_mul(longint a, longint b);
        logic   neg;
        longint ma;
        longint mb;
        longint r;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        r   = (ma * mb + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return neg ? -r : r;
    endfunction

    function automatic longint raise_pow(longint u, longint n);
        longint r;
        r = longint'(1) << FRAC_BITS;
        for (longint i = 0; i < n; i++)
        begin
            r = round_mul(r, u);
        end
        return r;
    endfunction

    function automatic res_t clip_out(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << (OUT_W - 1)) - 1;
        lo = -(longint'(1) << (OUT_W - 1));
        if (v > hi)
        begin
            v = hi;
        end
        if (v < lo)
        begin
            v = lo;
        end
        return res_t'(v);
    endfunction

    function automatic deg_result_t degradation_of(logic signed [PH_W-1:0] phase);
        longint      one;
        longint      ph;
        longint      u;
        longint      u2;
        longint      u3;
        longint      k0;
        longint      km;
        longint      p;
        longint      d;
        longint      s;
        longint      c;
        logic        bad;
        deg_result_t r;
        one = longint'(1) << FRAC_BITS;
        ph  = phase;
        d   = 0;
        s   = 0;
        c   = 0;
        bad = 1'b0;
        p   = longint'(cur_order);
        if (ph < 0)
        begin
            ph = 0;
        end
        if (ph > one)
        begin
            ph = one;
        end
        u  = one - ph;
        u2 = round_mul(u, u);
        if (FRAC_BITS >= 16)
        begin
            k0 = longint'(cur_k0) << (FRAC_BITS - 16);
        end
        else
        begin
            k0 = (longint'(cur_k0) + (longint'(1) << (15 - FRAC_BITS))) >> (16 - FRAC_BITS);
        end
        km = one - k0;
        case (cur_mode)
            MODE_NONE:
            begin
                d = one;
            end
            MODE_LIN:
            begin
                d = round_mul(km, u) + k0;
                s = -km;
            end
            MODE_LIN_NR:
            begin
                d = u;
                s = -one;
            end
            MODE_QUAD:
            begin
                d = round_mul(km, u2) + k0;
                s = -2 * round_mul(km, u);
                c = 2 * km;
            end
            MODE_QUAD_NR:
            begin
                d = u2;
                s = -2 * u;
                c = 2 * one;
            end
            MODE_CUBIC:
            begin
                d = round_mul(km, round_mul(u2, u)) + k0;
                s = -3 * round_mul(km, u2);
                c = 6 * round_mul(km, u);
            end
            MODE_CUBIC_NR:
            begin
                d = round_mul(u2, u);
                s = -3 * u2;
                c = 6 * u;
            end
            MODE_POWER:
            begin
                d = round_mul(km, raise_pow(u, p)) + k0;
                if (p >= 1)
                begin
                    s = -p * round_mul(km, raise_pow(u, p - 1));
                end
                if (p > 1)
                begin
                    c = p * (p - 1) * round_mul(km, raise_pow(u, p - 2));
                end
            end
            MODE_CZM:
            begin
                u3 = round_mul(u2, u);
                d  = round_mul(km, 2 * u2 - u3) + k0;
                s  = round_mul(km, 3 * u2 - 4 * u);
                c  = round_mul(km, 4 * one - 6 * u);
            end
            MODE_STEP20:
            begin
                d = (ph < (2 * one + 5) / 10) ? one : 0;
            end
            MODE_STEP50:
            begin
                d = (ph < one / 2) ? one : 0;
            end
            MODE_STEP80:
            begin
                d = (ph < (8 * one + 5) / 10) ? one : 0;
            end
            default:
            begin
                bad = 1'b1;
            end
        endcase
        r.deg = clip_out(d);
        r.slp = clip_out(s);
        r.crv = clip_out(c);
        r.bad = bad;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        deg_result_t want;
        deg_result_t got;
        if (!rst_n)
        begin
            cur_mode    <= MODE_QUAD;
            cur_k0      <= '0;
            cur_order   <= 4'd2;
            mismatches  <= 0;
            outstanding <= 0;
            expected_results.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[AW-1:2])
                    REG_MODE:  cur_mode  <= pwdata[3:0];
                    REG_K0:    cur_k0    <= pwdata[15:0];
                    REG_POWER: cur_order <= pwdata[3:0];
                    default:   ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(degradation_of(s_tdata));
            end
            if (m_tvalid && m_tready)
            begin
                got.deg = m_tdata[OUT_W-1:0];
                got.slp = m_tdata[2*OUT_W-1:OUT_W];
                got.crv = m_tdata[3*OUT_W-1:2*OUT_W];
                got.bad = m_tuser;
                if (expected_results.size() == 0)
                begin
                    $error("result with no request waiting: degradation %0d", got.deg);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got != want)
                    begin
                        if (got.deg != want.deg)
                        begin
                            $error("degradation: expected %0d, got %0d", want.deg, got.deg);
                        end
                        if (got.slp != want.slp)
                        begin
                            $error("slope: expected %0d, got %0d", want.slp, got.slp);
                        end
                        if (got.crv != want.crv)
                        begin
                            $error("curvature: expected %0d, got %0d", want.crv, got.crv);
                        end
                        if (got.bad != want.bad)
                        begin
                            $error("bad_mode: expected %0d, got %0d", want.bad, got.bad);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

// ===== tb/sv/phase_field_degradation_function_unit_test.sv =====
// Top of the degradation unit bench: clock, reset, phase requests, result back-pressure
// and register writes; the verdict comes from the mismatch and outstanding counts of pfdf_result_checker.
// Depends on pfdf_pkg, pfdf_result_checker and phase_field_degradation_function_unit.
module phase_field_degradation_function_unit_test;
    import pfdf_pkg::*;

    localparam int SETTLE_CYCLES = 25;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [PH_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [TDO_W-1:0] m_tdata;
    logic             m_tuser;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AW-1:0]    paddr;
    logic [DW-1:0]    pwdata;
    logic [DW-1:0]    prdata;
    logic             pready;
    int               mismatches;
    int               outstanding;
    int               sender_gap_pct;
    int               receiver_stall_pct;
    int               phases_sent;

    phase_field_degradation_function_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    pfdf_result_checker result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        #4000000;
        $display("phase_field_degradation_function_unit_test: FAIL");
        $finish;
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // saturation limits, clamp points and step thresholds
    function automatic logic [PH_W-1:0] boundary_phase(int k);
        case (k)
            0:       return {1'b1, {(PH_W-1){1'b0}}};
            1:       return {1'b0, {(PH_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            4:       return PH_W'(ONE_INT);
            5:       return PH_W'(ONE_INT - 1);
            6:       return PH_W'(ONE_INT + 1);
            7:       return PH_W'(TH20 - 1);
            8:       return PH_W'(TH20);
            9:       return PH_W'(TH50 - 1);
            10:      return PH_W'(TH50);
            11:      return PH_W'(TH80 - 1);
            12:      return PH_W'(TH80);
            default: return PH_W'(1);
        endcase
    endfunction

    function automatic logic [PH_W-1:0] pick_phase();
        int r;
        r = $urandom_range(99);
        if (r < 15)
        begin
            return boundary_phase($urandom_range(13));
        end
        if (r < 80)
        begin
            return PH_W'($urandom_range(ONE_INT));
        end
        return PH_W'($urandom);
    endfunction

    task automatic send_phase(input logic [PH_W-1:0] x);
        if (phases_sent < 512)
        begin
            sender_gap_pct     = 6;
            receiver_stall_pct = 73;
        end
        else if (phases_sent < 1024)
        begin
            sender_gap_pct     = 73;
            receiver_stall_pct = 6;
        end
        else
        begin
            sender_gap_pct     = 0;
            receiver_stall_pct = 0;
        end
        while ($urandom_range(99) < sender_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        phases_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AW'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic apply_setting(input logic [3:0] mode, input logic [15:0] k0,
                                 input logic [3:0] order);
        s_tvalid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(REG_MODE, DW'(mode));
        write_reg(REG_K0, DW'(k0));
        write_reg(REG_POWER, DW'(order));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] k0;
        rst_n              = 1'b0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        phases_sent        = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int k = 0; k < 14; k++)
        begin
            send_phase(boundary_phase(k));
        end

        // every mode, then every power order, then random settings
        for (int n = 0; n < 40; n++)
        begin
            case (n % 3)
                0:       k0 = 16'h0000;
                1:       k0 = 16'hFFFF;
                default: k0 = 16'($urandom);
            endcase
            if (n < 16)
            begin
                apply_setting(4'(n), k0, 4'($urandom_range(15)));
            end
            else if (n < 32)
            begin
                apply_setting(MODE_POWER, k0, 4'(n - 16));
            end
            else
            begin
                apply_setting(4'($urandom_range(15)), 16'($urandom), 4'($urandom_range(15)));
            end
            for (int i = 0; i < 38; i++)
            begin
                send_phase(pick_phase());
            end
        end

        s_tvalid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("phase_field_degradation_function_unit_test: PASS");
        end
        else
        begin
            $display("phase_field_degradation_function_unit_test: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pfdf_pkg.sv
rtl/pfdf_cfg.sv
rtl/phase_field_degradation_function_unit.sv
tb/sv/pfdf_result_checker.sv
tb/sv/phase_field_degradation_function_unit_test.sv
